### rtl/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int FUNC_W = 3;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;

  localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FIND    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REVERSE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_LENGTH  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [1:0] {CUR_HOLD, CUR_START, CUR_HEAD, CUR_NEXT} cur_op_t;
  typedef enum logic [1:0] {K_HOLD, K_ONE, K_ZERO, K_INC} k_op_t;
  typedef enum logic [1:0] {WA_CUR, WA_FNEW, WA_PREV, WA_INIT} wa_sel_t;
  typedef enum logic [2:0] {WD_HEAD, WD_FREE, WD_BUILT, WD_LQ, WD_FNEW, WD_INIT} wd_sel_t;
  typedef enum logic [1:0] {HD_HOLD, HD_FNEW, HD_LQ, HD_BUILT} head_op_t;
  typedef enum logic [1:0] {FR_HOLD, FR_FNEXT, FR_CUR} free_op_t;
  typedef enum logic [1:0] {CN_HOLD, CN_INC, CN_DEC} cnt_op_t;
  typedef enum logic {VS_ZERO, VS_VQ} vsel_t;
  typedef enum logic [1:0] {IS_ZERO, IS_K, IS_CNT} isel_t;

  typedef struct packed {
    logic              latch;
    cur_op_t           cur_op;
    k_op_t             k_op;
    logic              lk_we;
    wa_sel_t           lk_wa;
    wd_sel_t           lk_wd;
    logic              val_we;
    logic              save_fnew;
    logic              save_prev;
    head_op_t          head_op;
    free_op_t          free_op;
    cnt_op_t           cnt_op;
    logic              built_clr;
    logic              built_cur;
    logic              init_inc;
    logic              res_set;
    logic [STAT_W-1:0] res_stat;
    vsel_t             res_vsel;
    isel_t             res_isel;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              ins_pos_bad;
    logic              pos_bad;
    logic              pos_one;
    logic              cnt_zero;
    logic              full;
    logic              k_eq_tgt;
    logic              k_eq_cnt;
    logic              val_match;
    logic              init_last;
    logic              out_busy;
  } stat_t;

endpackage

### rtl/ple_ctrl.sv
module ple_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ple_pkg::stat_t  st,
  output ple_pkg::cmd_t   cmd
);

  typedef enum logic [9:0] {
    S_INIT  = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_CHECK = 10'b00_0000_0100,
    S_WALK  = 10'b00_0000_1000,
    S_FIND  = 10'b00_0001_0000,
    S_REV   = 10'b00_0010_0000,
    S_INSH  = 10'b00_0100_0000,
    S_INS2  = 10'b00_1000_0000,
    S_DEL2  = 10'b01_0000_0000,
    S_RESP  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   del3_r, del3_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      del3_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      del3_r  <= del3_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    del3_nxt  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.lk_we    = 1'b1;
        cmd.lk_wa    = ple_pkg::WA_INIT;
        cmd.lk_wd    = ple_pkg::WD_INIT;
        cmd.init_inc = 1'b1;
        if (st.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          cmd.cur_op = ple_pkg::CUR_START;
          cmd.k_op   = ple_pkg::K_ONE;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt   = S_RESP;
        cmd.res_set = 1'b1;
        cmd.res_stat = ple_pkg::ST_OK;
        case (st.func)
          ple_pkg::FN_INSERT: begin
            priority if (st.ins_pos_bad) begin
              cmd.res_stat = ple_pkg::ST_BAD_POS;
            end else if (st.full) begin
              cmd.res_stat = ple_pkg::ST_FULL;
            end else begin
              cmd.res_set   = 1'b0;
              cmd.save_fnew = 1'b1;
              cmd.cur_op    = ple_pkg::CUR_HEAD;
              cmd.k_op      = ple_pkg::K_ONE;
              state_nxt     = st.pos_one ? S_INSH : S_WALK;
            end
          end
          ple_pkg::FN_DELETE: begin
            priority if (st.cnt_zero) begin
              cmd.res_stat = ple_pkg::ST_EMPTY;
            end else if (st.pos_bad) begin
              cmd.res_stat = ple_pkg::ST_BAD_POS;
            end else if (st.pos_one) begin
              cmd.head_op = ple_pkg::HD_LQ;
              cmd.lk_we   = 1'b1;
              cmd.lk_wa   = ple_pkg::WA_CUR;
              cmd.lk_wd   = ple_pkg::WD_FREE;
              cmd.free_op = ple_pkg::FR_CUR;
              cmd.cnt_op  = ple_pkg::CN_DEC;
            end else begin
              cmd.res_set = 1'b0;
              state_nxt   = S_WALK;
            end
          end
          ple_pkg::FN_FIND: begin
            if (st.cnt_zero) begin
              cmd.res_stat = ple_pkg::ST_NOT_FOUND;
            end else begin
              cmd.res_set = 1'b0;
              state_nxt   = S_FIND;
            end
          end
          ple_pkg::FN_READ: begin
            priority if (st.cnt_zero) begin
              cmd.res_stat = ple_pkg::ST_EMPTY;
            end else if (st.pos_bad) begin
              cmd.res_stat = ple_pkg::ST_BAD_POS;
            end else begin
              cmd.res_set = 1'b0;
              state_nxt   = S_WALK;
            end
          end
          ple_pkg::FN_REVERSE: begin
            cmd.res_set   = 1'b0;
            cmd.k_op      = ple_pkg::K_ZERO;
            cmd.built_clr = 1'b1;
            state_nxt     = S_REV;
          end
          ple_pkg::FN_LENGTH: begin
            cmd.res_isel = ple_pkg::IS_CNT;
          end
          default: begin
            cmd.res_stat = ple_pkg::ST_OK;
          end
        endcase
      end
      S_WALK: begin
        if (st.k_eq_tgt) begin
          case (st.func)
            ple_pkg::FN_INSERT: begin
              cmd.lk_we = 1'b1;
              cmd.lk_wa = ple_pkg::WA_FNEW;
              cmd.lk_wd = ple_pkg::WD_LQ;
              state_nxt = S_INS2;
            end
            ple_pkg::FN_DELETE: begin
              cmd.save_prev = 1'b1;
              cmd.cur_op    = ple_pkg::CUR_NEXT;
              state_nxt     = S_DEL2;
            end
            default: begin
              cmd.res_set  = 1'b1;
              cmd.res_stat = ple_pkg::ST_OK;
              cmd.res_vsel = ple_pkg::VS_VQ;
              state_nxt    = S_RESP;
            end
          endcase
        end else begin
          cmd.cur_op = ple_pkg::CUR_NEXT;
          cmd.k_op   = ple_pkg::K_INC;
        end
      end
      S_FIND: begin
        priority if (st.val_match) begin
          cmd.res_set  = 1'b1;
          cmd.res_stat = ple_pkg::ST_OK;
          cmd.res_isel = ple_pkg::IS_K;
          state_nxt    = S_RESP;
        end else if (st.k_eq_cnt) begin
          cmd.res_set  = 1'b1;
          cmd.res_stat = ple_pkg::ST_NOT_FOUND;
          state_nxt    = S_RESP;
        end else begin
          cmd.cur_op = ple_pkg::CUR_NEXT;
          cmd.k_op   = ple_pkg::K_INC;
        end
      end
      S_REV: begin
        if (st.k_eq_cnt) begin
          cmd.head_op  = ple_pkg::HD_BUILT;
          cmd.res_set  = 1'b1;
          cmd.res_stat = ple_pkg::ST_OK;
          state_nxt    = S_RESP;
        end else begin
          cmd.lk_we     = 1'b1;
          cmd.lk_wa     = ple_pkg::WA_CUR;
          cmd.lk_wd     = ple_pkg::WD_BUILT;
          cmd.built_cur = 1'b1;
          cmd.cur_op    = ple_pkg::CUR_NEXT;
          cmd.k_op      = ple_pkg::K_INC;
        end
      end
      S_INSH: begin
        cmd.lk_we    = 1'b1;
        cmd.lk_wa    = ple_pkg::WA_FNEW;
        cmd.lk_wd    = ple_pkg::WD_HEAD;
        cmd.val_we   = 1'b1;
        cmd.head_op  = ple_pkg::HD_FNEW;
        cmd.free_op  = ple_pkg::FR_FNEXT;
        cmd.cnt_op   = ple_pkg::CN_INC;
        cmd.res_set  = 1'b1;
        cmd.res_stat = ple_pkg::ST_OK;
        state_nxt    = S_RESP;
      end
      S_INS2: begin
        cmd.lk_we    = 1'b1;
        cmd.lk_wa    = ple_pkg::WA_CUR;
        cmd.lk_wd    = ple_pkg::WD_FNEW;
        cmd.val_we   = 1'b1;
        cmd.free_op  = ple_pkg::FR_FNEXT;
        cmd.cnt_op   = ple_pkg::CN_INC;
        cmd.res_set  = 1'b1;
        cmd.res_stat = ple_pkg::ST_OK;
        state_nxt    = S_RESP;
      end
      S_DEL2: begin
        cmd.lk_we = 1'b1;
        if (!del3_r) begin
          cmd.lk_wa = ple_pkg::WA_PREV;
          cmd.lk_wd = ple_pkg::WD_LQ;
          del3_nxt  = 1'b1;
        end else begin
          cmd.lk_wa    = ple_pkg::WA_CUR;
          cmd.lk_wd    = ple_pkg::WD_FREE;
          cmd.free_op  = ple_pkg::FR_CUR;
          cmd.cnt_op   = ple_pkg::CN_DEC;
          cmd.res_set  = 1'b1;
          cmd.res_stat = ple_pkg::ST_OK;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

### rtl/ple_dpath.sv
module ple_dpath #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [ple_pkg::FUNC_W-1:0]        in_func,
  input  logic [ple_pkg::POS_W-1:0]         in_position,
  input  logic signed [ple_pkg::VAL_W-1:0]  in_value,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [ple_pkg::STAT_W-1:0]        out_status,
  output logic signed [ple_pkg::VAL_W-1:0]  out_value_out,
  output logic [ple_pkg::POS_W-1:0]         out_index_out,
  input  ple_pkg::cmd_t                     cmd,
  output ple_pkg::stat_t                    st
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = ple_pkg::POS_W;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  logic [ple_pkg::VAL_W-1:0] vals [CAPACITY];
  logic [LW-1:0]             links [CAPACITY];

  logic [ple_pkg::FUNC_W-1:0] f_r;
  logic [PW-1:0]              pos_r;
  logic [ple_pkg::VAL_W-1:0]  val_r;
  logic [LW-1:0] head_r, head_nxt, free_r, free_nxt, cnt_r, cnt_nxt;
  logic [LW-1:0] cur_r, cur_nxt, fnew_r, fnext_r, prev_r, built_r;
  logic [LW-1:0] lq_r, lk_wa, lk_wd;
  logic [ple_pkg::VAL_W-1:0] vq_r;
  logic [PW-1:0] k_r, k_nxt, tgt;
  logic [AW-1:0] init_r;
  logic [ple_pkg::STAT_W-1:0] res_stat_r;
  logic [ple_pkg::VAL_W-1:0]  res_v_r;
  logic [PW-1:0]              res_i_r;
  logic out_valid_r;
  logic [ple_pkg::STAT_W-1:0] out_stat_r;
  logic [ple_pkg::VAL_W-1:0]  out_v_r;
  logic [PW-1:0]              out_i_r;

  always_comb begin
    unique case (cmd.cur_op)
      ple_pkg::CUR_START: cur_nxt = (in_func == ple_pkg::FN_INSERT) ? free_r : head_r;
      ple_pkg::CUR_HEAD:  cur_nxt = head_r;
      ple_pkg::CUR_NEXT:  cur_nxt = lq_r;
      default:            cur_nxt = cur_r;
    endcase
    unique case (cmd.k_op)
      ple_pkg::K_ONE:  k_nxt = PW'(1);
      ple_pkg::K_ZERO: k_nxt = '0;
      ple_pkg::K_INC:  k_nxt = k_r + PW'(1);
      default:         k_nxt = k_r;
    endcase
    unique case (cmd.lk_wa)
      ple_pkg::WA_FNEW: lk_wa = fnew_r;
      ple_pkg::WA_PREV: lk_wa = prev_r;
      ple_pkg::WA_INIT: lk_wa = LW'(init_r);
      default:          lk_wa = cur_r;
    endcase
    unique case (cmd.lk_wd)
      ple_pkg::WD_FREE:  lk_wd = free_r;
      ple_pkg::WD_BUILT: lk_wd = built_r;
      ple_pkg::WD_LQ:    lk_wd = lq_r;
      ple_pkg::WD_FNEW:  lk_wd = fnew_r;
      ple_pkg::WD_INIT:  lk_wd = LW'(init_r) + LW'(1);
      default:           lk_wd = head_r;
    endcase
    unique case (cmd.head_op)
      ple_pkg::HD_FNEW:  head_nxt = fnew_r;
      ple_pkg::HD_LQ:    head_nxt = lq_r;
      ple_pkg::HD_BUILT: head_nxt = built_r;
      default:           head_nxt = head_r;
    endcase
    unique case (cmd.free_op)
      ple_pkg::FR_FNEXT: free_nxt = fnext_r;
      ple_pkg::FR_CUR:   free_nxt = cur_r;
      default:           free_nxt = free_r;
    endcase
    unique case (cmd.cnt_op)
      ple_pkg::CN_INC: cnt_nxt = cnt_r + LW'(1);
      ple_pkg::CN_DEC: cnt_nxt = cnt_r - LW'(1);
      default:         cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.lk_we) links[lk_wa[AW-1:0]] <= lk_wd;
    lq_r <= links[cur_nxt[AW-1:0]];
    if (cmd.val_we) vals[fnew_r[AW-1:0]] <= val_r;
    vq_r <= vals[cur_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NIL;
      free_r      <= '0;
      cnt_r       <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      free_r <= free_nxt;
      cnt_r  <= cnt_nxt;
      if (cmd.init_inc) init_r <= init_r + AW'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    k_r   <= k_nxt;
    if (cmd.latch) begin
      f_r   <= in_func;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.save_fnew) begin
      fnew_r  <= cur_r;
      fnext_r <= lq_r;
    end
    if (cmd.save_prev) prev_r <= cur_r;
    if (cmd.built_clr) built_r <= NIL;
    else if (cmd.built_cur) built_r <= cur_r;
    if (cmd.res_set) begin
      res_stat_r <= cmd.res_stat;
      res_v_r    <= (cmd.res_vsel == ple_pkg::VS_VQ) ? vq_r : '0;
      unique case (cmd.res_isel)
        ple_pkg::IS_K:   res_i_r <= k_r;
        ple_pkg::IS_CNT: res_i_r <= PW'(cnt_r);
        default:         res_i_r <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_stat_r <= res_stat_r;
      out_v_r    <= res_v_r;
      out_i_r    <= res_i_r;
    end
  end

  assign tgt = (f_r == ple_pkg::FN_READ) ? pos_r : pos_r - PW'(1);

  always_comb begin
    st.func        = f_r;
    st.ins_pos_bad = (pos_r == '0) || ({1'b0, pos_r} > ({1'b0, PW'(cnt_r)} + 9'd1));
    st.pos_bad     = (pos_r == '0) || (pos_r > PW'(cnt_r));
    st.pos_one     = (pos_r == PW'(1));
    st.cnt_zero    = (cnt_r == '0);
    st.full        = (free_r == NIL) || (cnt_r >= NIL);
    st.k_eq_tgt    = (k_r == tgt);
    st.k_eq_cnt    = (k_r == PW'(cnt_r));
    st.val_match   = (vq_r == val_r);
    st.init_last   = (init_r == AW'(CAPACITY - 1));
    st.out_busy    = out_valid_r && out_stall;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_stat_r;
  assign out_value_out = out_v_r;
  assign out_index_out = out_i_r;

endmodule

### rtl/positional_list_engine.sv
// Ordered list of signed 32-bit values kept as a singly linked list in a
// node store of CAPACITY entries, with a free chain for unused nodes.
// Input channel (in_valid/in_stall): one transaction carries func, position
// and value. Output channel (out_valid/out_stall): one transaction per input
// carries status, value_out and index_out.
// After reset the link memory is chained into the free list, one node per
// cycle: in_stall stays high until every node is chained, then the list is empty.
// Each item passes through accept and check, then a walk over the links in
// the link memory (single read port, registered read), up to two write-back
// steps, and a load into the output register.
// One item is in work at a time. A finished result sits in the output
// register; the block accepts the next transaction while it waits, and a
// second result waits until out_stall drops. A stalled output holds.
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ple_pkg::FUNC_W-1:0]        in_func,
  input  logic [ple_pkg::POS_W-1:0]         in_position,
  input  logic signed [ple_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ple_pkg::STAT_W-1:0]        out_status,
  output logic signed [ple_pkg::VAL_W-1:0]  out_value_out,
  output logic [ple_pkg::POS_W-1:0]         out_index_out
);

  ple_pkg::cmd_t  cmd;
  ple_pkg::stat_t st;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ple_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_index_out (out_index_out),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

### rtl/ple_checker.sv
module ple_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [ple_pkg::FUNC_W-1:0]        in_func,
  input logic [ple_pkg::POS_W-1:0]         in_position,
  input logic signed [ple_pkg::VAL_W-1:0]  in_value,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [ple_pkg::STAT_W-1:0]        out_status,
  input logic signed [ple_pkg::VAL_W-1:0]  out_value_out,
  input logic [ple_pkg::POS_W-1:0]         out_index_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_value_out) && $stable(out_index_out))
    else $error("stalled output transaction changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ple_pkg::ST_OK) || (out_status == ple_pkg::ST_BAD_POS)
      || (out_status == ple_pkg::ST_FULL) || (out_status == ple_pkg::ST_EMPTY)
      || (out_status == ple_pkg::ST_NOT_FOUND))
    else $error("status code out of range");

  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_value_out != '0) |-> out_status == ple_pkg::ST_OK)
    else $error("value returned with an error status");

  a_index_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_index_out != '0) |-> out_status == ple_pkg::ST_OK)
    else $error("index returned with an error status");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);

### tb/sv/positional_list_engine_test.sv
`timescale 1ns / 100ps

module positional_list_engine_test;

  localparam int CAP = ple_pkg::CAPACITY_DEF;
  localparam int NIL = CAP;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [ple_pkg::FUNC_W-1:0] FN_UNUSED_LO = 3'd6;
  localparam logic [ple_pkg::FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [ple_pkg::FUNC_W-1:0] func;
    logic [ple_pkg::POS_W-1:0]  position;
    logic [ple_pkg::VAL_W-1:0]  value;
  } request_t;

  typedef struct packed {
    logic [ple_pkg::STAT_W-1:0] status;
    logic [ple_pkg::VAL_W-1:0]  value_out;
    logic [ple_pkg::POS_W-1:0]  index_out;
  } response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ple_pkg::FUNC_W-1:0] in_func = '0;
  logic [ple_pkg::POS_W-1:0] in_position = '0;
  logic signed [ple_pkg::VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ple_pkg::STAT_W-1:0] out_status;
  logic signed [ple_pkg::VAL_W-1:0] out_value_out;
  logic [ple_pkg::POS_W-1:0] out_index_out;

  positional_list_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_position(in_position), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_value_out(out_value_out),
    .out_index_out(out_index_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t  pending_reqs[$];
  response_t expected_resps[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  // shadow list state
  logic [ple_pkg::VAL_W-1:0] shadow_vals[CAP];
  int shadow_links[CAP];
  int shadow_head, shadow_free, shadow_count;

  function automatic int walk_to(int pos);
    int n;
    n = shadow_head;
    for (int k = 1; k < pos && n != NIL; k++) n = shadow_links[n];
    return n;
  endfunction

  function automatic response_t apply_request(request_t r);
    response_t rsp;
    int n, prev, rest, built, p;
    rsp = '0;
    p = r.position;
    case (r.func)
      ple_pkg::FN_INSERT: begin
        if (p == 0 || p > shadow_count + 1) rsp.status = ple_pkg::ST_BAD_POS;
        else if (shadow_free == NIL || shadow_count >= CAP) rsp.status = ple_pkg::ST_FULL;
        else begin
          n = shadow_free;
          shadow_free = shadow_links[n];
          shadow_vals[n] = r.value;
          if (p == 1) begin
            shadow_links[n] = shadow_head;
            shadow_head = n;
          end else begin
            prev = walk_to(p - 1);
            shadow_links[n] = shadow_links[prev];
            shadow_links[prev] = n;
          end
          shadow_count++;
        end
      end
      ple_pkg::FN_DELETE: begin
        if (shadow_count == 0) rsp.status = ple_pkg::ST_EMPTY;
        else if (p == 0 || p > shadow_count) rsp.status = ple_pkg::ST_BAD_POS;
        else begin
          if (p == 1) begin
            n = shadow_head;
            shadow_head = shadow_links[n];
          end else begin
            prev = walk_to(p - 1);
            n = shadow_links[prev];
            shadow_links[prev] = shadow_links[n];
          end
          shadow_links[n] = shadow_free;
          shadow_free = n;
          shadow_count--;
        end
      end
      ple_pkg::FN_FIND: begin
        rsp.status = ple_pkg::ST_NOT_FOUND;
        n = shadow_head;
        for (int k = 1; k <= shadow_count && n != NIL; k++) begin
          if (shadow_vals[n] == r.value) begin
            rsp.status = ple_pkg::ST_OK;
            rsp.index_out = ple_pkg::POS_W'(k);
            break;
          end
          n = shadow_links[n];
        end
      end
      ple_pkg::FN_READ: begin
        if (shadow_count == 0) rsp.status = ple_pkg::ST_EMPTY;
        else if (p == 0 || p > shadow_count) rsp.status = ple_pkg::ST_BAD_POS;
        else rsp.value_out = shadow_vals[walk_to(p)];
      end
      ple_pkg::FN_REVERSE: begin
        rest = shadow_head;
        built = NIL;
        for (int k = 0; k < shadow_count && rest != NIL; k++) begin
          n = rest;
          rest = shadow_links[n];
          shadow_links[n] = built;
          built = n;
        end
        shadow_head = built;
      end
      ple_pkg::FN_LENGTH: rsp.index_out = ple_pkg::POS_W'(shadow_count);
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [ple_pkg::VAL_W-1:0] got,
                                 logic [ple_pkg::VAL_W-1:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  int drive_wait = 0;
  logic in_taken, out_taken;
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
  end

  // driver: change inputs at the falling edge after the accepting rising edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_taken) drive_wait = $urandom_range(0, 3);
      if (!in_valid || in_taken) begin
        if (drive_wait > 0) begin
          drive_wait--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          request_t r;
          r = pending_reqs.pop_front();
          expected_resps.push_back(apply_request(r));
          in_func <= r.func;
          in_position <= r.position;
          in_value <= r.value;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int stall_left = 0;
  always @(negedge clk) begin
    if (out_taken) stall_left = $urandom_range(0, 3);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_resps.size() == 0) begin
        report_mismatch("unexpected transaction", ple_pkg::VAL_W'(out_status), '0);
      end else begin
        response_t e;
        e = expected_resps.pop_front();
        if (out_status !== e.status)
          report_mismatch("status", ple_pkg::VAL_W'(out_status), ple_pkg::VAL_W'(e.status));
        if (out_value_out !== e.value_out)
          report_mismatch("value_out", out_value_out, e.value_out);
        if (out_index_out !== e.index_out)
          report_mismatch("index_out", ple_pkg::VAL_W'(out_index_out),
                          ple_pkg::VAL_W'(e.index_out));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic request_t make_req(logic [ple_pkg::FUNC_W-1:0] f, int p,
                                        logic [ple_pkg::VAL_W-1:0] v);
    request_t r;
    r.func = f;
    r.position = ple_pkg::POS_W'(p);
    r.value = v;
    return r;
  endfunction

  // mirrors queued requests so stimulus knows the list length ahead of time
  int plan_count = 0;
  logic [ple_pkg::VAL_W-1:0] plan_vals[$];

  task automatic plan(logic [ple_pkg::FUNC_W-1:0] f, int p, logic [ple_pkg::VAL_W-1:0] v);
    pending_reqs.push_back(make_req(f, p, v));
    if (f == ple_pkg::FN_INSERT && p >= 1 && p <= plan_count + 1 && plan_count < CAP) begin
      plan_vals.insert(p - 1, v);
      plan_count++;
    end else if (f == ple_pkg::FN_DELETE && p >= 1 && p <= plan_count) begin
      plan_vals.delete(p - 1);
      plan_count--;
    end else if (f == ple_pkg::FN_REVERSE) begin
      plan_vals.reverse();
    end
  endtask

  function automatic logic [ple_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [ple_pkg::FUNC_W-1:0] f;
    int p, pick;
    logic [ple_pkg::VAL_W-1:0] v;
    shadow_head = NIL;
    shadow_free = 0;
    shadow_count = 0;
    for (int k = 0; k < CAP; k++) begin
      shadow_links[k] = k + 1;
      shadow_vals[k] = '0;
    end
    plan(ple_pkg::FN_DELETE, 1, 0);
    plan(ple_pkg::FN_READ, 1, 0);
    plan(ple_pkg::FN_FIND, 0, 32'hdead_beef);
    plan(ple_pkg::FN_REVERSE, 0, 0);
    plan(ple_pkg::FN_LENGTH, 0, 0);
    plan(ple_pkg::FN_INSERT, 0, 5);
    plan(ple_pkg::FN_INSERT, 2, 5);
    plan(ple_pkg::FN_INSERT, 1, 32'h8000_0000);
    plan(ple_pkg::FN_INSERT, 2, 32'h7fff_ffff);
    plan(ple_pkg::FN_INSERT, 1, 32'hffff_ffff);
    plan(ple_pkg::FN_INSERT, 255, 1);
    plan(ple_pkg::FN_READ, 0, 0);
    plan(ple_pkg::FN_READ, 4, 0);
    plan(ple_pkg::FN_READ, 3, 0);
    plan(ple_pkg::FN_FIND, 0, 32'h7fff_ffff);
    plan(ple_pkg::FN_REVERSE, 0, 0);
    plan(ple_pkg::FN_READ, 1, 0);
    plan(ple_pkg::FN_DELETE, 4, 0);
    plan(ple_pkg::FN_DELETE, 0, 0);
    plan(ple_pkg::FN_DELETE, 2, 0);
    plan(FN_UNUSED_LO, 255, 32'hffff_ffff);
    plan(FN_UNUSED_HI, 1, 32'h1234_5678);
    plan(ple_pkg::FN_LENGTH, 0, 0);
    for (int i = 0; i < 500; i++) begin
      pick = $urandom_range(0, 99);
      v = rand_value();
      if (pick < 3) f = ($urandom_range(0, 1) == 0) ? FN_UNUSED_LO : FN_UNUSED_HI;
      else if (plan_count >= CAP - 2 && pick < 50) f = ple_pkg::FN_DELETE;
      else if (pick < 35) f = ple_pkg::FN_INSERT;
      else if (pick < 52) f = ple_pkg::FN_DELETE;
      else if (pick < 67) f = ple_pkg::FN_FIND;
      else if (pick < 85) f = ple_pkg::FN_READ;
      else if (pick < 92) f = ple_pkg::FN_REVERSE;
      else f = ple_pkg::FN_LENGTH;
      if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 255);
      else p = $urandom_range(1, plan_count + 1);
      if (f == ple_pkg::FN_FIND && plan_count > 0 && $urandom_range(0, 2) > 0)
        v = plan_vals[$urandom_range(0, plan_count - 1)];
      plan(f, p, v);
    end
    while (plan_count < CAP) plan(ple_pkg::FN_INSERT, plan_count + 1, $urandom);
    plan(ple_pkg::FN_INSERT, 1, 9);
    plan(ple_pkg::FN_INSERT, CAP + 1, 9);
    plan(ple_pkg::FN_REVERSE, 0, 0);
    plan(ple_pkg::FN_FIND, 0, plan_vals[CAP - 1]);
    plan(ple_pkg::FN_READ, CAP, 0);
    plan(ple_pkg::FN_DELETE, CAP, 0);
    plan(ple_pkg::FN_LENGTH, 0, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (in_valid || expected_resps.size() > 0) @(posedge clk);
    repeat (CAP + 10) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
